// ----- hdl/rsu_pkg.sv -----
// Shared types and constants of the rotor substitution unit.
package rsu_pkg;

	localparam int ALPHABET_SIZE_DEF = 95;

	localparam int CMD_W = 3;
	localparam int SYM_W = 8;
	localparam int PORT_IDX_W = 7;

	localparam logic [SYM_W-1:0] FIRST_CODE = 8'd32;

	localparam logic [CMD_W-1:0] CMD_LOAD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ENCODE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DECODE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STEP_FWD = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STEP_BACK = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH,
		ST_TOP,
		ST_CAPT
	} rsu_state_t;

endpackage

// ----- hdl/rsu_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module rsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 95
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// ----- hdl/rotor_substitution_unit_core.sv -----
// Rotor substitution unit: wiring RAM, rotor position and search sequencer.
//
// channel | words                                           | handshake
// in      | command, symbol, load_index                     | in_valid / in_stall
// out     | result_symbol, matched, top_symbol, rotor_position | out_valid / out_stall
//
// Load, encode, step and unknown commands run through EXEC, TOP and CAPT to the result.
// Decode runs SEARCH between EXEC and TOP, until a hit or the middle; the two-port wiring RAM
// compares one entry from each end of the search per cycle.
// Reset clears the position to zero; the wiring RAM is not cleared.
// A new word is taken while a result waits; a stalled result holds the last step.
module rotor_substitution_unit_core import rsu_pkg::*; #(
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      command,
	input  logic [SYM_W-1:0]      symbol,
	input  logic [PORT_IDX_W-1:0] load_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SYM_W-1:0]      result_symbol,
	output logic                  matched,
	output logic [SYM_W-1:0]      top_symbol,
	output logic [PORT_IDX_W-1:0] rotor_position
);

	localparam int IDX_W = $clog2(ALPHABET_SIZE);
	localparam logic [IDX_W:0] N_EXT = (IDX_W+1)'(ALPHABET_SIZE);
	localparam logic [IDX_W-1:0] N_LAST = IDX_W'(ALPHABET_SIZE - 1);
	localparam logic [IDX_W-1:0] K_LAST = IDX_W'((ALPHABET_SIZE - 1) / 2);
	localparam logic [SYM_W:0] N_CMP = (SYM_W+1)'(ALPHABET_SIZE);

	function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= N_EXT) begin
			s = s - N_EXT;
		end
		return s[IDX_W-1:0];
	endfunction

	rsu_state_t state_q, state_nxt;

	logic [CMD_W-1:0]      cmd_q;
	logic [SYM_W-1:0]      sym_q;
	logic [PORT_IDX_W-1:0] idx_q;
	logic [IDX_W-1:0]      pos_q;
	logic [IDX_W-1:0]      k_q;
	logic [IDX_W-1:0]      kp_q;
	logic                  pend_q;
	logic [SYM_W-1:0]      res_q;
	logic                  hit_q;

	logic                  out_valid_q;
	logic [SYM_W-1:0]      res_out_q;
	logic                  hit_out_q;
	logic [SYM_W-1:0]      top_out_q;
	logic [PORT_IDX_W-1:0] pos_out_q;

	logic                  accept;
	logic                  out_free;
	logic                  out_load;
	logic                  ram_we;
	logic [IDX_W-1:0]      addr_a;
	logic [IDX_W-1:0]      addr_b;
	logic [SYM_W-1:0]      rd_a;
	logic [SYM_W-1:0]      rd_b;
	logic [SYM_W-1:0]      code_off;
	logic                  enc_ok;
	logic                  load_ok;
	logic [IDX_W-1:0]      code_idx;
	logic [IDX_W-1:0]      far_idx;
	logic                  hit_a;
	logic                  hit_b;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign code_off = sym_q - FIRST_CODE;
	assign enc_ok   = (sym_q >= FIRST_CODE) && ({1'b0, code_off} < N_CMP);
	assign load_ok  = {2'b00, idx_q} < N_CMP;
	assign code_idx = IDX_W'(code_off);
	assign far_idx  = N_LAST - kp_q;
	assign hit_a    = rd_a == sym_q;
	assign hit_b    = rd_b == sym_q;

	rsu_ram #(
		.WIDTH (SYM_W),
		.DEPTH (ALPHABET_SIZE)
	) u_rsu_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (IDX_W'(idx_q)),
		.wdata   (sym_q),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cmd_q == CMD_DECODE) begin
					state_nxt = ST_SEARCH;
				end else begin
					state_nxt = ST_TOP;
				end
			end
			ST_SEARCH: begin
				if (pend_q && (hit_a || hit_b || kp_q == K_LAST)) begin
					state_nxt = ST_TOP;
				end
			end
			ST_TOP: begin
				state_nxt = ST_CAPT;
			end
			ST_CAPT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		ram_we   = 1'b0;
		out_load = 1'b0;
		addr_a   = pos_q;
		addr_b   = pos_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_EXEC: begin
				ram_we = (cmd_q == CMD_LOAD) && load_ok;
			end
			ST_SEARCH: begin
				addr_a = mod_add(k_q, pos_q);
				addr_b = mod_add(N_LAST - k_q, pos_q);
			end
			ST_TOP: begin
				addr_b = enc_ok ? mod_add(code_idx, pos_q) : pos_q;
			end
			ST_CAPT: begin
				addr_b   = enc_ok ? mod_add(code_idx, pos_q) : pos_q;
				out_load = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_EXEC) begin
				pend_q <= 1'b0;
				unique case (cmd_q)
					CMD_STEP_FWD: begin
						pos_q <= (pos_q == N_LAST) ? '0 : pos_q + 1'b1;
					end
					CMD_STEP_BACK: begin
						pos_q <= (pos_q == '0) ? N_LAST : pos_q - 1'b1;
					end
					default: begin
						pos_q <= pos_q;
					end
				endcase
			end else if (state_q == ST_SEARCH) begin
				pend_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			sym_q <= symbol;
			idx_q <= load_index;
		end
		unique case (state_q)
			ST_EXEC: begin
				res_q <= sym_q;
				hit_q <= 1'b0;
				k_q   <= '0;
			end
			ST_SEARCH: begin
				k_q  <= k_q + 1'b1;
				kp_q <= k_q;
				if (pend_q && hit_a) begin
					res_q <= FIRST_CODE + SYM_W'(kp_q);
					hit_q <= 1'b1;
				end else if (pend_q && hit_b) begin
					res_q <= FIRST_CODE + SYM_W'(far_idx);
					hit_q <= 1'b1;
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
		if (out_load) begin
			if (cmd_q == CMD_ENCODE) begin
				res_out_q <= enc_ok ? rd_b : sym_q;
				hit_out_q <= enc_ok;
			end else begin
				res_out_q <= res_q;
				hit_out_q <= hit_q;
			end
			top_out_q <= rd_a;
			pos_out_q <= PORT_IDX_W'(pos_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign result_symbol  = res_out_q;
	assign matched        = hit_out_q;
	assign top_symbol     = top_out_q;
	assign rotor_position = pos_out_q;

endmodule

// ----- hdl/rsu_checker.sv -----
// Port-level assertions for the rotor substitution unit, with bind.
module rsu_checker import rsu_pkg::*; #(
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [SYM_W-1:0]      result_symbol,
	input logic                  matched,
	input logic [SYM_W-1:0]      top_symbol,
	input logic [PORT_IDX_W-1:0] rotor_position
);

	localparam bit POS_FITS = ALPHABET_SIZE <= (1 << PORT_IDX_W);
	localparam logic [PORT_IDX_W:0] N_CMP = (PORT_IDX_W+1)'(ALPHABET_SIZE);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in work");

	a_result_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("word finished without a result");

	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && POS_FITS |-> {1'b0, rotor_position} < N_CMP)
		else $error("rotor position out of range");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_symbol)
			&& $stable(matched) && $stable(top_symbol) && $stable(rotor_position))
		else $error("stalled result changed");

endmodule

bind rotor_substitution_unit_core rsu_checker #(
	.ALPHABET_SIZE (ALPHABET_SIZE)
) u_rsu_checker (.*);
